// ===== rtl/ptg_pkg.sv =====
`default_nettype none

package ptg_pkg;

	localparam int PADDR_W = 3;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW = 3;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic REG_CELL_INVERSE = 1'b0;
	localparam logic REG_SENSOR_HEIGHT = 1'b1;

	localparam logic [31:0] CELL_INVERSE_RESET = 32'd655360;
	localparam logic [30:0] SENSOR_HEIGHT_RESET = 31'd0;

	localparam logic [7:0] UNKNOWN_CELL = 8'hFF;
	localparam logic [7:0] HEIGHT_MAX = 8'd127;
	localparam logic [32:0] QUARTER_M2 = 33'h0_4000_0000;

	typedef struct packed {
		logic valid;
		logic rd;
		logic wr;
		logic hit;
		logic [7:0] value;
		logic [15:0] index;
	} ptg_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/ptg_geom.sv =====
`default_nettype none

module ptg_geom #(
	parameter int GRID_W = 256,
	parameter int GRID_H = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic valid_s1,
	input wire logic opcode_s1,
	input wire logic [31:0] point_x_s1,
	input wire logic [31:0] point_y_s1,
	input wire logic [31:0] point_z_s1,
	input wire logic [15:0] cell_index_s1,
	input wire logic [31:0] cell_inverse,
	input wire logic [30:0] sensor_height,
	output ptg_pkg::ptg_cmd_t cmd_s3,
	output logic [$clog2(GRID_W * GRID_H)-1:0] gx_s3,
	output logic [$clog2(GRID_W * GRID_H)-1:0] gy_s3
);
	import ptg_pkg::*;

	localparam int NCELLS = GRID_W * GRID_H;
	localparam int AW = $clog2(NCELLS);
	localparam int GXW = $clog2(GRID_W) + 2;
	localparam int GYW = $clog2(GRID_H) + 2;
	localparam logic [63:0] WIN_X = 64'(GRID_W) << 31;
	localparam logic [63:0] WIN_Y = 64'(GRID_H) << 31;
	localparam logic [GXW-1:0] HALF_W = GXW'(GRID_W / 2);
	localparam logic [GYW-1:0] HALF_H = GYW'(GRID_H / 2);
	localparam logic [GXW-1:0] LIM_W = GXW'(GRID_W);
	localparam logic [GYW-1:0] LIM_H = GYW'(GRID_H);
	localparam logic [31:0] NCELLS_32 = 32'(NCELLS);

	logic [31:0] mx;
	logic [31:0] my;

	logic valid_s2;
	logic rd_s2;
	logic [15:0] index_s2;
	logic [63:0] ax_s2;
	logic [63:0] ay_s2;
	logic [31:0] sqx_s2;
	logic [31:0] sqy_s2;
	logic big_s2;
	logic [32:0] sum_s2;
	logic px_pos_s2;
	logic py_pos_s2;

	logic [GXW-1:0] tx;
	logic [GYW-1:0] ty;
	logic [GXW-1:0] gx;
	logic [GYW-1:0] gy;
	logic win_ok;
	logic height_ok;
	logic far_ok;
	logic keep;
	logic [7:0] value;

	assign mx = point_y_s1[31] ? (~point_y_s1 + 32'd1) : point_y_s1;
	assign my = point_x_s1[31] ? (~point_x_s1 + 32'd1) : point_x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rd_s2 <= (opcode_s1 == OP_READ);
		index_s2 <= cell_index_s1;
		ax_s2 <= {32'd0, mx} * {32'd0, cell_inverse};
		ay_s2 <= {32'd0, my} * {32'd0, cell_inverse};
		sqx_s2 <= {16'd0, mx[15:0]} * {16'd0, mx[15:0]};
		sqy_s2 <= {16'd0, my[15:0]} * {16'd0, my[15:0]};
		big_s2 <= (|mx[31:16]) || (|my[31:16]);
		sum_s2 <= {point_z_s1[31], point_z_s1} + {2'b00, sensor_height};
		px_pos_s2 <= !point_x_s1[31] && (point_x_s1 != 32'd0);
		py_pos_s2 <= !point_y_s1[31] && (point_y_s1 != 32'd0);
	end

	assign tx = ax_s2[32 +: GXW];
	assign ty = ay_s2[32 +: GYW];
	assign gx = py_pos_s2 ? (HALF_W - tx) : (HALF_W + tx);
	assign gy = px_pos_s2 ? (HALF_H - ty) : (HALF_H + ty);
	assign win_ok = (ax_s2 <= WIN_X) && (ay_s2 <= WIN_Y);
	assign height_ok = !sum_s2[32] && (sum_s2 != 33'd0);
	assign far_ok = big_s2 || (({1'b0, sqx_s2} + {1'b0, sqy_s2}) > QUARTER_M2);
	assign keep = win_ok && height_ok && far_ok && (gx < LIM_W) && (gy < LIM_H);
	assign value = (|sum_s2[32:23]) ? HEIGHT_MAX : {1'b0, sum_s2[22:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s3 <= '0;
		end else begin
			cmd_s3.valid <= valid_s2;
			cmd_s3.rd <= rd_s2;
			cmd_s3.wr <= valid_s2 && !rd_s2 && keep;
			cmd_s3.hit <= ({16'd0, index_s2} < NCELLS_32);
			cmd_s3.value <= value;
			cmd_s3.index <= index_s2;
		end
	end

	always_ff @(posedge clk) begin
		gx_s3 <= AW'(gx);
		gy_s3 <= AW'(gy);
	end

endmodule

`default_nettype wire

// ===== rtl/ptg_out_fifo.sv =====
`default_nettype none

module ptg_out_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic [7:0] push_data,
	input wire logic pop,
	output logic valid,
	output logic [7:0] data
);
	import ptg_pkg::*;

	logic [7:0] slots_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q;
	logic [OUT_AW-1:0] rd_ptr_q;
	logic [OUT_AW:0] count_q;
	logic do_pop;

	assign valid = (count_q != '0);
	assign data = slots_q[rd_ptr_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/point_to_height_grid.sv =====
// A read request returns cell_value through the output FIFO; inserts give no result.
// One request a clock while req_ready is high; the cell memory's write and read port sets that.
// Every request is refused while eight read results are outstanding and not yet taken.
// After reset the registers take their reset values and a sweep writes unknown (-1) to
// every cell, one a clock, GRID_W * GRID_H of them (65536 by default), while req_ready is low.
`default_nettype none

module point_to_height_grid #(
	parameter int GRID_W = 256,
	parameter int GRID_H = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ptg_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic req_valid,
	output logic req_ready,
	input wire logic opcode,
	input wire logic signed [31:0] point_x,
	input wire logic signed [31:0] point_y,
	input wire logic signed [31:0] point_z,
	input wire logic [15:0] cell_index,
	output logic res_valid,
	input wire logic res_ready,
	output logic signed [7:0] cell_value
);
	import ptg_pkg::*;

	localparam int NCELLS = GRID_W * GRID_H;
	localparam int AW = $clog2(NCELLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);

	logic [31:0] cell_inverse_q;
	logic [30:0] sensor_height_q;
	logic cfg_wr;

	logic clearing_q;
	logic [AW-1:0] clr_addr_q;

	logic [OUT_AW:0] pending_q;
	logic req_take;
	logic res_take;

	logic valid_s1;
	logic opcode_s1;
	logic [31:0] point_x_s1;
	logic [31:0] point_y_s1;
	logic [31:0] point_z_s1;
	logic [15:0] cell_index_s1;

	ptg_cmd_t cmd_s3;
	logic [AW-1:0] gx_s3;
	logic [AW-1:0] gy_s3;

	logic [7:0] cells_q [NCELLS];
	logic [AW-1:0] ins_addr;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0] mem_wdata;

	logic valid_s4;
	logic hit_s4;
	logic [7:0] rdata_s4;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_SENSOR_HEIGHT) ? {1'b0, sensor_height_q} : cell_inverse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_inverse_q <= CELL_INVERSE_RESET;
			sensor_height_q <= SENSOR_HEIGHT_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_SENSOR_HEIGHT) begin
				sensor_height_q <= pwdata[30:0];
			end else begin
				cell_inverse_q <= pwdata;
			end
		end
	end

	// Request handshake and the count of reads whose results are still owed.
	assign req_ready = !clearing_q && (pending_q < (OUT_AW + 1)'(OUT_DEPTH));
	assign req_take = req_valid && req_ready;
	assign res_take = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			if ((req_take && (opcode == OP_READ)) && !res_take) begin
				pending_q <= pending_q + 1'b1;
			end else if (!(req_take && (opcode == OP_READ)) && res_take) begin
				pending_q <= pending_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_CELL) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req_take;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			opcode_s1 <= opcode;
			point_x_s1 <= point_x;
			point_y_s1 <= point_y;
			point_z_s1 <= point_z;
			cell_index_s1 <= cell_index;
		end
	end

	ptg_geom #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_geom (
		.clk(clk),
		.arst_n(arst_n),
		.valid_s1(valid_s1),
		.opcode_s1(opcode_s1),
		.point_x_s1(point_x_s1),
		.point_y_s1(point_y_s1),
		.point_z_s1(point_z_s1),
		.cell_index_s1(cell_index_s1),
		.cell_inverse(cell_inverse_q),
		.sensor_height(sensor_height_q),
		.cmd_s3(cmd_s3),
		.gx_s3(gx_s3),
		.gy_s3(gy_s3)
	);

	// Cell memory: a read takes the old value and leaves the cell unknown.
	assign ins_addr = (gx_s3 * AW'(GRID_H)) + gy_s3;
	assign rd_addr = AW'(cmd_s3.index);
	assign mem_we = clearing_q || (cmd_s3.valid && (cmd_s3.wr || (cmd_s3.rd && cmd_s3.hit)));
	assign mem_waddr = clearing_q ? clr_addr_q : (cmd_s3.rd ? rd_addr : ins_addr);
	assign mem_wdata = (clearing_q || cmd_s3.rd) ? UNKNOWN_CELL : cmd_s3.value;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cells_q[mem_waddr] <= mem_wdata;
		end
		rdata_s4 <= cells_q[rd_addr];
		hit_s4 <= cmd_s3.hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= cmd_s3.valid && cmd_s3.rd;
		end
	end

	ptg_out_fifo u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(valid_s4),
		.push_data(hit_s4 ? rdata_s4 : UNKNOWN_CELL),
		.pop(res_ready),
		.valid(res_valid),
		.data(cell_value)
	);

endmodule

`default_nettype wire

// ===== rtl/ptg_check.sv =====
`default_nettype none

module ptg_check (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic pwrite,
	input wire logic [ptg_pkg::PADDR_W-1:0] paddr,
	input wire logic [31:0] prdata,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic opcode,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [7:0] cell_value
);
	import ptg_pkg::*;

	logic [15:0] owed_q;
	logic read_in;
	logic res_out;

	assign read_in = req_valid && req_ready && (opcode == OP_READ);
	assign res_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= '0;
		end else if (read_in && !res_out) begin
			owed_q <= owed_q + 16'd1;
		end else if (!read_in && res_out) begin
			owed_q <= owed_q - 16'd1;
		end
	end

	// A result held back by the consumer stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(cell_value))
		else $error("result changed while stalled");

	// Every result answers a read request taken earlier.
	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (owed_q != 16'd0))
		else $error("result without an outstanding read");

	// A cell holds either unknown or a height of 0 to 127 metres.
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!cell_value[7] || (cell_value == UNKNOWN_CELL)))
		else $error("cell value out of range");

	// The sensor height register is 31 bits wide.
	a_height_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && !pwrite && (paddr[2] == REG_SENSOR_HEIGHT) |-> !prdata[31])
		else $error("sensor height reads back with the top bit set");

endmodule

bind point_to_height_grid ptg_check u_check (.*);

`default_nettype wire
